@@ rtl/keyed_multi_stack_store_defines.svh @@
// ----------------------------------------------------------------------------
// keyed_multi_stack_store_defines
// Assertion macros for the keyed stack table; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYED_MULTI_STACK_STORE_DEFINES_SVH
`define KEYED_MULTI_STACK_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KMSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kmss: same-cycle check failed");
// next-cycle implication
`define KMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kmss: next-cycle check failed");
`else
`define KMSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/kmss_pkg.sv @@
// ----------------------------------------------------------------------------
// kmss_pkg
// Shared types and codes of the keyed stack table.
// ----------------------------------------------------------------------------
`default_nettype none

package kmss_pkg;

	localparam int KEY_W  = 16;
	localparam int ITEM_W = 16;

	// command codes
	typedef enum logic [1:0] {
		ACT_PUSH = 2'd0,
		ACT_POP  = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_ADD  = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_EMPTY      = 2'd1,
		STS_STACK_FULL = 2'd2,
		STS_TABLE_FULL = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_TOP  = 2'd2,
		ST_EXEC = 2'd3
	} state_t;

	typedef struct packed {
		action_t             action;
		logic [KEY_W-1:0]    user_id;
		logic [ITEM_W-1:0]   item_value;
	} cmd_t;

	typedef struct packed {
		logic [ITEM_W-1:0]   item_out;
		logic                item_valid;
		status_t             status;
		logic                user_empty;
		logic                user_full;
	} result_t;

	// key scan outcome
	typedef struct packed {
		logic done;
		logic hit;
		logic free;
	} scan_flags_t;

	// slot table update request
	typedef struct packed {
		logic set;
		logic clr;
	} slot_upd_t;

endpackage

`default_nettype wire

@@ rtl/kmss_key_scan.sv @@
// ----------------------------------------------------------------------------
// kmss_key_scan
// Slot keys and valid bits; one shared comparator walks the slots one per
// cycle to find the matching slot and the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module kmss_key_scan import kmss_pkg::*; #(
	parameter int USERS = 16,
	localparam int IW = $clog2(USERS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             scan_start,
	input  wire logic [KEY_W-1:0] key,
	input  wire slot_upd_t        upd,
	input  wire logic [IW-1:0]    upd_idx,
	output scan_flags_t           flags,
	output logic [IW-1:0]         hit_idx,
	output logic [IW-1:0]         free_idx
);

	localparam logic [IW-1:0] LAST = IW'(USERS - 1);

	logic [KEY_W-1:0] key_mem [USERS];
	logic [USERS-1:0] valid_q;
	logic             run_q;
	logic [IW-1:0]    issue_idx_q;
	logic             cmp_en_s1;
	logic [IW-1:0]    cmp_idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic             done_q;
	logic             hit_q;
	logic             free_q;
	logic [IW-1:0]    hit_idx_q;
	logic [IW-1:0]    free_idx_q;
	logic             slot_match;
	logic             slot_free;

	// comparator on the slot read last cycle
	assign slot_free  = !valid_q[cmp_idx_s1];
	assign slot_match = valid_q[cmp_idx_s1] && (key_rd_s1 == key);

	// scan control and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			issue_idx_q <= '0;
			cmp_en_s1   <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			valid_q     <= '0;
		end else begin
			cmp_en_s1 <= run_q;
			done_q    <= cmp_en_s1 && (cmp_idx_s1 == LAST);
			if (scan_start) begin
				run_q       <= 1'b1;
				issue_idx_q <= '0;
				hit_q       <= 1'b0;
				free_q      <= 1'b0;
			end else begin
				if (run_q) begin
					if (issue_idx_q == LAST) begin
						run_q <= 1'b0;
					end else begin
						issue_idx_q <= issue_idx_q + IW'(1);
					end
				end
				if (cmp_en_s1) begin
					if (slot_match) begin
						hit_q <= 1'b1;
					end
					if (slot_free) begin
						free_q <= 1'b1;
					end
				end
			end
			if (upd.set) begin
				valid_q[upd_idx] <= 1'b1;
			end else if (upd.clr) begin
				valid_q[upd_idx] <= 1'b0;
			end
		end
	end

	// lowest matching and lowest free slot index
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= issue_idx_q;
		if (cmp_en_s1 && slot_match && !hit_q) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (cmp_en_s1 && slot_free && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// key memory, registered read
	always_ff @(posedge clk) begin
		if (upd.set) begin
			key_mem[upd_idx] <= key;
		end
		if (run_q) begin
			key_rd_s1 <= key_mem[issue_idx_q];
		end
	end

	assign flags.done = done_q;
	assign flags.hit  = hit_q;
	assign flags.free = free_q;
	assign hit_idx    = hit_idx_q;
	assign free_idx   = free_idx_q;

endmodule

`default_nettype wire

@@ rtl/kmss_stack_mem.sv @@
// ----------------------------------------------------------------------------
// kmss_stack_mem
// Per-slot stack heights and the shared item store, both with registered
// reads.
// ----------------------------------------------------------------------------
`default_nettype none

module kmss_stack_mem import kmss_pkg::*; #(
	parameter int USERS       = 16,
	parameter int STACK_SLOTS = 16,
	localparam int IW    = $clog2(USERS),
	localparam int HW    = $clog2(STACK_SLOTS),
	localparam int DEPTH = USERS * (STACK_SLOTS - 1),
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              hgt_rd_en,
	input  wire logic [IW-1:0]     hgt_rd_idx,
	output logic [HW-1:0]          hgt_rd_data,
	input  wire logic              hgt_wr_en,
	input  wire logic [IW-1:0]     hgt_wr_idx,
	input  wire logic [HW-1:0]     hgt_wr_data,
	input  wire logic              stk_rd_en,
	input  wire logic [AW-1:0]     stk_rd_addr,
	output logic [ITEM_W-1:0]      stk_rd_data,
	input  wire logic              stk_wr_en,
	input  wire logic [AW-1:0]     stk_wr_addr,
	input  wire logic [ITEM_W-1:0] stk_wr_data
);

	logic [HW-1:0]     hgt_mem [USERS];
	logic [ITEM_W-1:0] stk_mem [DEPTH];
	logic [HW-1:0]     hgt_rd_q;
	logic [ITEM_W-1:0] stk_rd_q;

	// height memory
	always_ff @(posedge clk) begin
		if (hgt_wr_en) begin
			hgt_mem[hgt_wr_idx] <= hgt_wr_data;
		end
		if (hgt_rd_en) begin
			hgt_rd_q <= hgt_mem[hgt_rd_idx];
		end
	end

	// item store
	always_ff @(posedge clk) begin
		if (stk_wr_en) begin
			stk_mem[stk_wr_addr] <= stk_wr_data;
		end
		if (stk_rd_en) begin
			stk_rd_q <= stk_mem[stk_rd_addr];
		end
	end

	assign hgt_rd_data = hgt_rd_q;
	assign stk_rd_data = stk_rd_q;

endmodule

`default_nettype wire

@@ rtl/keyed_multi_stack_store.sv @@
// ----------------------------------------------------------------------------
// keyed_multi_stack_store
// Table of keyed slots, each with a private stack: push, pop, peek, add user.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: drive cmd and raise start; the command transfers at a
//   rising edge where start is high and busy is low. busy then stays high
//   until the result is out.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver must take it then, there is no back-pressure.
//   Sequence: each command runs the key scan, which compares one slot per cycle
//   through a single comparator behind a registered key read, then a height
//   read, an item read and an update step; done follows the update. The next
//   command can transfer at the edge that ends that done cycle, so commands
//   do not overlap.
//   Reset: arst_n clears all slot valid bits and the sequencer; keys, heights
//   and items are not cleared; heights and items are only read once written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_multi_stack_store_defines.svh"

module keyed_multi_stack_store import kmss_pkg::*; #(
	parameter int USERS       = 16,
	parameter int STACK_SLOTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire cmd_t cmd,
	output logic      done,
	output result_t   result
);

	localparam int IW  = $clog2(USERS);
	localparam int HW  = $clog2(STACK_SLOTS);
	localparam int AW  = $clog2(USERS * (STACK_SLOTS - 1));
	localparam logic [HW-1:0] CAP_H = HW'(STACK_SLOTS - 1);
	localparam logic [AW-1:0] CAP_A = AW'(STACK_SLOTS - 1);

	state_t            state_q;
	state_t            state_d;
	cmd_t              cmd_q;
	result_t           res_q;
	result_t           res_d;
	logic              done_q;
	logic              accept;
	logic              scan_start;
	logic              hgt_rd_en;
	logic              stk_rd_en;
	logic              exec_en;
	scan_flags_t       flags;
	logic [IW-1:0]     hit_idx;
	logic [IW-1:0]     free_idx;
	logic [IW-1:0]     tgt;
	logic [IW-1:0]     tgt_q;
	logic [AW-1:0]     base_q;
	logic [HW-1:0]     hgt;
	logic [ITEM_W-1:0] top_item;
	slot_upd_t         upd;
	logic              hgt_wr_en;
	logic [HW-1:0]     hgt_wr_data;
	logic              stk_wr_en;
	logic [AW-1:0]     stk_wr_addr;
	logic [AW-1:0]     stk_rd_addr;

	// key scan unit
	kmss_key_scan #(
		.USERS(USERS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_start(scan_start),
		.key       (cmd_q.user_id),
		.upd       (upd),
		.upd_idx   (tgt_q),
		.flags     (flags),
		.hit_idx   (hit_idx),
		.free_idx  (free_idx)
	);

	// heights and item store
	kmss_stack_mem #(
		.USERS      (USERS),
		.STACK_SLOTS(STACK_SLOTS)
	) u_mem (
		.clk        (clk),
		.hgt_rd_en  (hgt_rd_en),
		.hgt_rd_idx (hit_idx),
		.hgt_rd_data(hgt),
		.hgt_wr_en  (hgt_wr_en),
		.hgt_wr_idx (tgt_q),
		.hgt_wr_data(hgt_wr_data),
		.stk_rd_en  (stk_rd_en),
		.stk_rd_addr(stk_rd_addr),
		.stk_rd_data(top_item),
		.stk_wr_en  (stk_wr_en),
		.stk_wr_addr(stk_wr_addr),
		.stk_wr_data(cmd_q.item_value)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (flags.done) begin
					state_d = ST_TOP;
				end
			end
			ST_TOP:  state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		accept     = start && (state_q == ST_IDLE);
		scan_start = accept;
		hgt_rd_en  = (state_q == ST_SCAN) && flags.done && flags.hit;
		stk_rd_en  = (state_q == ST_TOP) && flags.hit && (hgt != '0);
		exec_en    = (state_q == ST_EXEC);
	end

	// target slot and the address of its top item
	assign tgt         = flags.hit ? hit_idx : free_idx;
	assign stk_rd_addr = base_q + AW'(hgt) - AW'(1);

	// command execution
	always_comb begin
		res_d       = '0;
		res_d.status = STS_OK;
		upd         = '0;
		hgt_wr_en   = 1'b0;
		hgt_wr_data = hgt;
		stk_wr_en   = 1'b0;
		stk_wr_addr = base_q;
		unique case (cmd_q.action)
			ACT_PUSH: begin
				if (!flags.hit) begin
					if (!flags.free) begin
						res_d.status     = STS_TABLE_FULL;
						res_d.user_empty = 1'b1;
					end else begin
						upd.set         = 1'b1;
						hgt_wr_en       = 1'b1;
						hgt_wr_data     = HW'(1);
						stk_wr_en       = 1'b1;
						res_d.user_full = (CAP_H == HW'(1));
					end
				end else if (hgt == CAP_H) begin
					res_d.status     = STS_STACK_FULL;
					res_d.user_empty = (hgt == '0);
					res_d.user_full  = 1'b1;
				end else begin
					stk_wr_en       = 1'b1;
					stk_wr_addr     = base_q + AW'(hgt);
					hgt_wr_en       = 1'b1;
					hgt_wr_data     = hgt + HW'(1);
					res_d.user_full = ((hgt + HW'(1)) == CAP_H);
				end
			end
			ACT_ADD: begin
				if (!flags.hit) begin
					res_d.user_empty = 1'b1;
					if (!flags.free) begin
						res_d.status = STS_TABLE_FULL;
					end else begin
						upd.set     = 1'b1;
						hgt_wr_en   = 1'b1;
						hgt_wr_data = '0;
					end
				end else begin
					res_d.user_empty = (hgt == '0);
					res_d.user_full  = (hgt == CAP_H);
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (!flags.hit || (hgt == '0)) begin
					res_d.status     = STS_EMPTY;
					res_d.user_empty = 1'b1;
				end else begin
					res_d.item_out   = top_item;
					res_d.item_valid = 1'b1;
					if (cmd_q.action == ACT_POP) begin
						hgt_wr_en   = 1'b1;
						hgt_wr_data = hgt - HW'(1);
						// last item gone: release the slot
						if (hgt == HW'(1)) begin
							upd.clr          = 1'b1;
							res_d.user_empty = 1'b1;
						end
					end else begin
						res_d.user_full = (hgt == CAP_H);
					end
				end
			end
			default: res_d = '0;
		endcase
		if (!exec_en) begin
			upd       = '0;
			hgt_wr_en = 1'b0;
			stk_wr_en = 1'b0;
		end
	end

	// sequencer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= exec_en;
		end
	end

	// command, target and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if ((state_q == ST_SCAN) && flags.done) begin
			tgt_q  <= tgt;
			base_q <= AW'(tgt) * CAP_A;
		end
		if (exec_en) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// checks
	`KMSS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`KMSS_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	`KMSS_ASSERT_IMPLY(a_item_ok, clk, arst_n, done && result.item_valid, result.status == STS_OK)
	`KMSS_ASSERT_IMPLY(a_full_not_empty, clk, arst_n, done && result.user_full, !result.user_empty)

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed stack table. A short directed table runs
// first (empty table, one-item stack, filling a stack and the whole table),
// then random command streams over small and large key pools. Every command
// is scored against a typed expectation or a bench copy of slots and stacks.
// ----------------------------------------------------------------------------
module tb import kmss_pkg::*;;

	localparam int USERS       = 16;
	localparam int STACK_SLOTS = 16;
	localparam int DEPTH       = STACK_SLOTS - 1;
	localparam int N_RANDOM    = 800;
	// worst case is about 860 commands, each a full key scan, plus random idle
	// cycles and drains; the limit leaves a wide margin over that
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		action_t     act;
		logic [15:0] key;
		logic [15:0] val;
		int          reps;
		bit          key_step;
		bit          typed;
		result_t     exp;
	} stim_row_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;

	// bench copy of the slot table
	bit          tbl_valid  [USERS];
	logic [15:0] tbl_key    [USERS];
	int          tbl_height [USERS];
	logic [15:0] tbl_items  [USERS][DEPTH];

	result_t owed_results[$];
	int      mismatches = 0;
	int      cycles     = 0;

	keyed_multi_stack_store #(
		.USERS       (USERS),
		.STACK_SLOTS (STACK_SLOTS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// run-time watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// apply one command to the bench table and return what the block should report
	function automatic result_t stack_table_apply(input cmd_t c);
		result_t r;
		int      hit;
		int      free_slot;
		r         = '0;
		r.status  = STS_OK;
		hit       = -1;
		free_slot = -1;
		// lowest matching slot and lowest free slot
		for (int i = USERS - 1; i >= 0; i--) begin
			if (tbl_valid[i] && tbl_key[i] == c.user_id)
				hit = i;
			if (!tbl_valid[i])
				free_slot = i;
		end
		case (c.action)
			ACT_PUSH: begin
				if (hit < 0) begin
					if (free_slot < 0) begin
						r.status = STS_TABLE_FULL;
					end else begin
						hit                = free_slot;
						tbl_valid[hit]     = 1'b1;
						tbl_key[hit]       = c.user_id;
						tbl_height[hit]    = 1;
						tbl_items[hit][0]  = c.item_value;
					end
				end else if (tbl_height[hit] >= DEPTH) begin
					r.status = STS_STACK_FULL;
				end else begin
					tbl_items[hit][tbl_height[hit]] = c.item_value;
					tbl_height[hit]++;
				end
			end
			ACT_ADD: begin
				if (hit < 0) begin
					if (free_slot < 0) begin
						r.status = STS_TABLE_FULL;
					end else begin
						hit             = free_slot;
						tbl_valid[hit]  = 1'b1;
						tbl_key[hit]    = c.user_id;
						tbl_height[hit] = 0;
					end
				end
			end
			default: begin
				// pop and peek
				if (hit < 0 || tbl_height[hit] == 0) begin
					r.status = STS_EMPTY;
				end else begin
					r.item_out   = tbl_items[hit][tbl_height[hit] - 1];
					r.item_valid = 1'b1;
					if (c.action == ACT_POP) begin
						tbl_height[hit]--;
						// last item gone: slot is released
						if (tbl_height[hit] == 0) begin
							tbl_valid[hit] = 1'b0;
							hit            = -1;
						end
					end
				end
			end
		endcase
		r.user_empty = (hit < 0) || (tbl_height[hit] == 0);
		r.user_full  = (hit >= 0) && (tbl_height[hit] >= DEPTH);
		return r;
	endfunction

	function automatic stim_row_t mk_row(input action_t act, input logic [15:0] key,
			input logic [15:0] val, input int reps, input bit key_step, input bit typed,
			input logic [15:0] item, input logic valid, input status_t sts,
			input logic empty, input logic full);
		stim_row_t r;
		r.act              = act;
		r.key              = key;
		r.val              = val;
		r.reps             = reps;
		r.key_step         = key_step;
		r.typed            = typed;
		r.exp.item_out     = item;
		r.exp.item_valid   = valid;
		r.exp.status       = sts;
		r.exp.user_empty   = empty;
		r.exp.user_full    = full;
		return r;
	endfunction

	// one command transfer; where idling is allowed, start drops at random cycles
	task automatic issue(input cmd_t c, input bit typed, input result_t typed_exp,
			input bit may_idle);
		result_t pred;
		bit      idle;
		bit      taken;
		taken = 1'b0;
		while (!taken) begin
			idle = may_idle && ($urandom_range(0, 99) < 29);
			start <= !idle;
			cmd   <= c;
			@(posedge clk);
			taken = !idle && !busy;
		end
		pred = stack_table_apply(c);
		owed_results.push_back(typed ? typed_exp : pred);
	endtask

	// hold off until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0) @(posedge clk);
	endtask

	// result scoreboard
	always @(posedge clk) begin : score
		result_t want;
		bit      bad;
		string   why;
		if (arst_n && done) begin
			want = '0;
			bad  = 1'b1;
			why  = "unexpected result";
			if (owed_results.size() != 0) begin
				want = owed_results.pop_front();
				why  = "result mismatch";
				bad  = (result.item_out   !== want.item_out)   ||
				       (result.item_valid !== want.item_valid) ||
				       (result.status     !== want.status)     ||
				       (result.user_empty !== want.user_empty) ||
				       (result.user_full  !== want.user_full);
			end
			if (bad) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("%0t %s: exp item=%h v=%b sts=%0d e=%b f=%b act item=%h v=%b sts=%0d e=%b f=%b",
						$time, why, want.item_out, want.item_valid, want.status,
						want.user_empty, want.user_full, result.item_out, result.item_valid,
						result.status, result.user_empty, result.user_full);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		stim_row_t   tab[$];
		cmd_t        c;
		logic [15:0] keys[20];
		int          psize;
		int          phase;
		int          pick;
		int          push_pct;
		int          pop_pct;

		// directed rows: typed expectations where they are obvious
		tab.push_back(mk_row(ACT_PEEK, 16'h0000, 16'h0000, 1, 0, 1, 16'h0000, 0, STS_EMPTY, 1, 0));
		tab.push_back(mk_row(ACT_POP,  16'hFFFF, 16'h0000, 1, 0, 1, 16'h0000, 0, STS_EMPTY, 1, 0));
		tab.push_back(mk_row(ACT_PUSH, 16'hFFFF, 16'hFFFF, 1, 0, 1, 16'h0000, 0, STS_OK, 0, 0));
		tab.push_back(mk_row(ACT_PEEK, 16'hFFFF, 16'h0000, 1, 0, 1, 16'hFFFF, 1, STS_OK, 0, 0));
		tab.push_back(mk_row(ACT_POP,  16'hFFFF, 16'h0000, 1, 0, 1, 16'hFFFF, 1, STS_OK, 1, 0));
		// slot was released by the pop
		tab.push_back(mk_row(ACT_PEEK, 16'hFFFF, 16'h0000, 1, 0, 1, 16'h0000, 0, STS_EMPTY, 1, 0));
		tab.push_back(mk_row(ACT_ADD,  16'h0000, 16'h0000, 1, 0, 1, 16'h0000, 0, STS_OK, 1, 0));
		// add for a user already present
		tab.push_back(mk_row(ACT_ADD,  16'h0000, 16'h0000, 1, 0, 1, 16'h0000, 0, STS_OK, 1, 0));
		// pop on an added empty stack keeps the slot
		tab.push_back(mk_row(ACT_POP,  16'h0000, 16'h0000, 1, 0, 1, 16'h0000, 0, STS_EMPTY, 1, 0));
		// fill one stack, then overflow it
		tab.push_back(mk_row(ACT_PUSH, 16'h0000, 16'h0000, DEPTH, 0, 0, '0, 0, STS_OK, 0, 0));
		tab.push_back(mk_row(ACT_PUSH, 16'h0000, 16'h5A5A, 1, 0, 1, 16'h0000, 0,
			STS_STACK_FULL, 0, 1));
		tab.push_back(mk_row(ACT_PEEK, 16'h0000, 16'h0000, 1, 0, 0, '0, 0, STS_OK, 0, 0));
		// fill the whole table, then try new users
		tab.push_back(mk_row(ACT_ADD,  16'h0001, 16'h0000, USERS - 1, 1, 0, '0, 0, STS_OK, 0, 0));
		tab.push_back(mk_row(ACT_PUSH, 16'h1234, 16'h1111, 1, 0, 1, 16'h0000, 0,
			STS_TABLE_FULL, 1, 0));
		tab.push_back(mk_row(ACT_ADD,  16'hABCD, 16'h0000, 1, 0, 1, 16'h0000, 0,
			STS_TABLE_FULL, 1, 0));
		tab.push_back(mk_row(ACT_PUSH, 16'h0001, 16'h8001, 1, 0, 0, '0, 0, STS_OK, 0, 0));
		tab.push_back(mk_row(ACT_POP,  16'h0001, 16'h0000, 1, 0, 0, '0, 0, STS_OK, 0, 0));
		tab.push_back(mk_row(ACT_PUSH, 16'h1234, 16'h7FFF, 1, 0, 0, '0, 0, STS_OK, 0, 0));
		// empty the full stack, which frees its slot
		tab.push_back(mk_row(ACT_POP,  16'h0000, 16'h0000, DEPTH, 0, 0, '0, 0, STS_OK, 0, 0));
		tab.push_back(mk_row(ACT_PEEK, 16'h0000, 16'h0000, 1, 0, 1, 16'h0000, 0, STS_EMPTY, 1, 0));

		foreach (keys[i])
			keys[i] = 16'($urandom_range(0, 65535));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tab[r]) begin
			for (int k = 0; k < tab[r].reps; k++) begin
				c.action     = tab[r].act;
				c.user_id    = tab[r].key + (tab[r].key_step ? 16'(k) : 16'h0000);
				c.item_value = tab[r].val + 16'(k);
				issue(c, tab[r].typed, tab[r].exp, 1'b1);
			end
		end

		// random streams: phases alternate pool size and push/pop balance
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0) begin
				drain();
				phase    = (n / 100) % 4;
				psize    = (phase % 2 == 1) ? 3 : 20;
				push_pct = (phase < 2) ? 55 : 25;
				pop_pct  = (phase < 2) ? 20 : 45;
			end
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				c.action = ACT_PUSH;
			else if (pick < push_pct + pop_pct)
				c.action = ACT_POP;
			else if (pick < push_pct + pop_pct + 15)
				c.action = ACT_PEEK;
			else
				c.action = ACT_ADD;
			c.user_id    = ($urandom_range(0, 99) < 80) ? keys[$urandom_range(0, psize - 1)]
			                                            : 16'($urandom);
			c.item_value = 16'($urandom);
			// a long run with back-to-back commands
			issue(c, 1'b0, '0, !(n >= 300 && n < 450));
		end

		drain();
		repeat (USERS + 8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ keyed_multi_stack_store.f @@
+incdir+rtl
rtl/kmss_pkg.sv
rtl/kmss_key_scan.sv
rtl/kmss_stack_mem.sv
rtl/keyed_multi_stack_store.sv
test/tb.sv
